[hdl/tisf_pkg.sv]
// shared types and constants for the telnet iac sequence framer
// no dependencies; imported by tisf_step and telnet_iac_sequence_framer
package tisf_pkg;

  localparam int MaxLen   = 4095;
  localparam int LenCap   = (MaxLen < 4095) ? MaxLen : 4095;
  localparam int CountW   = 12;

  localparam logic [7:0] ByteIac  = 8'd255;
  localparam logic [7:0] ByteDont = 8'd254;
  localparam logic [7:0] ByteDo   = 8'd253;
  localparam logic [7:0] ByteWont = 8'd252;
  localparam logic [7:0] ByteWill = 8'd251;
  localparam logic [7:0] ByteSb   = 8'd250;
  localparam logic [7:0] ByteSe   = 8'd240;

  localparam logic [CountW-1:0] LenOpt3 = CountW'(3);
  localparam logic [CountW-1:0] LenCmd2 = CountW'(2);

  typedef enum logic [2:0] {
    StPending  = 3'd0,
    StComplete = 3'd1,
    StNotSeq   = 3'd2,
    StAfterEnd = 3'd3,
    StTooLong  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PhFirst  = 3'd0,
    PhCmd    = 3'd1,
    PhOpt3   = 3'd2,
    PhSbOpt  = 3'd3,
    PhSbBody = 3'd4,
    PhSbIac  = 3'd5,
    PhDone   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_buffer;
  } in_beat_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] seq_length;
  } out_beat_t;

  // scan state carried between beats
  typedef struct packed {
    phase_e            phase;
    logic [CountW-1:0] count;
  } scan_t;

endpackage

[hdl/telnet_iac_sequence_framer.sv]
// Telnet IAC sequence framer. Each input beat carries one buffer byte and a
// start-of-buffer flag; each input beat yields exactly one result beat with a
// status (pending, complete, not a sequence, after end, too long) and the
// command length when complete. One byte per clock is sustained while the
// output is not stalled: a beat sits in the input register while the scan
// logic works on it, then moves to the result register, so throughput is set only
// by downstream stall. After reset, bytes without a start flag report after end.
// depends on tisf_pkg and tisf_step
module telnet_iac_sequence_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tisf_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tisf_pkg::out_beat_t  out_beat_o
);
  import tisf_pkg::*;

  logic      s1_valid_q;
  in_beat_t  s1_beat_q;
  logic      out_valid_q;
  out_beat_t out_beat_q;
  scan_t     scan_q;
  scan_t     scan_d;
  out_beat_t result;
  logic      advance;

  // the result register frees up when empty or when its beat is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  tisf_step u_step (
    .scan_i   (scan_q),
    .beat_i   (s1_beat_q),
    .scan_o   (scan_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      scan_q.phase <= PhDone;
      scan_q.count <= '0;
    end else begin
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (advance) out_valid_q <= s1_valid_q;
      if (advance && s1_valid_q) scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) s1_beat_q <= in_beat_i;
    if (advance && s1_valid_q) out_beat_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_len_when_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status == StComplete |-> out_beat_o.seq_length >= LenCmd2)
    else $error("complete result with length below two");

  a_len_zero_otherwise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.status != StComplete |-> out_beat_o.seq_length == '0)
    else $error("nonzero length on a non-complete result");

  a_done_after_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q && result.status != StPending |=> scan_q.phase == PhDone)
    else $error("scan not finished after an answer");

  a_count_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, scan_q.count} <= (CountW+1)'(LenCap))
    else $error("byte count past the length limit");

  a_stall_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in the pipeline");

endmodule

[hdl/tisf_step.sv]
// per-beat scan logic: next scan state and result for one byte
// depends on tisf_pkg
module tisf_step (
  input  tisf_pkg::scan_t    scan_i,
  input  tisf_pkg::in_beat_t beat_i,
  output tisf_pkg::scan_t    scan_o,
  output tisf_pkg::out_beat_t result_o
);
  import tisf_pkg::*;

  phase_e            cur_phase;
  logic [CountW-1:0] cur_count;
  logic [CountW:0]   next_count;
  logic              too_long;
  logic              is_opt_cmd;

  // a start flag restarts the scan on this very byte
  assign cur_phase  = beat_i.start_of_buffer ? PhFirst : scan_i.phase;
  assign cur_count  = beat_i.start_of_buffer ? '0 : scan_i.count;
  assign next_count = {1'b0, cur_count} + (CountW+1)'(1);
  assign too_long   = next_count > (CountW+1)'(LenCap);
  assign is_opt_cmd = (beat_i.data_byte == ByteDo)   || (beat_i.data_byte == ByteDont) ||
                      (beat_i.data_byte == ByteWill) || (beat_i.data_byte == ByteWont);

  // next state
  always_comb begin
    scan_o.phase = cur_phase;
    scan_o.count = cur_count;
    if (cur_phase == PhDone || cur_phase > PhDone || too_long) begin
      scan_o.phase = PhDone;
    end else begin
      scan_o.count = next_count[CountW-1:0];
      unique case (cur_phase)
        PhFirst:  scan_o.phase = (beat_i.data_byte == ByteIac) ? PhCmd : PhDone;
        PhCmd: begin
          if (is_opt_cmd) begin
            scan_o.phase = PhOpt3;
          end else if (beat_i.data_byte == ByteSb) begin
            scan_o.phase = PhSbOpt;
          end else begin
            scan_o.phase = PhDone;
          end
        end
        PhOpt3:   scan_o.phase = PhDone;
        PhSbOpt:  scan_o.phase = PhSbBody;
        PhSbBody: scan_o.phase = (beat_i.data_byte == ByteIac) ? PhSbIac : PhSbBody;
        PhSbIac:  scan_o.phase = (beat_i.data_byte == ByteSe) ? PhDone : PhSbBody;
        default:  scan_o.phase = PhDone;
      endcase
    end
  end

  // result of this byte
  always_comb begin
    result_o.status     = StPending;
    result_o.seq_length = '0;
    if (cur_phase == PhDone || cur_phase > PhDone) begin
      result_o.status = StAfterEnd;
    end else if (too_long) begin
      result_o.status = StTooLong;
    end else begin
      unique case (cur_phase)
        PhFirst: begin
          if (beat_i.data_byte != ByteIac) result_o.status = StNotSeq;
        end
        PhCmd: begin
          if (!is_opt_cmd && beat_i.data_byte != ByteSb) begin
            result_o.status     = StComplete;
            result_o.seq_length = LenCmd2;
          end
        end
        PhOpt3: begin
          result_o.status     = StComplete;
          result_o.seq_length = LenOpt3;
        end
        PhSbIac: begin
          if (beat_i.data_byte == ByteSe) begin
            result_o.status     = StComplete;
            result_o.seq_length = next_count[CountW-1:0];
          end
        end
        default: result_o.status = StPending;
      endcase
    end
  end

endmodule
